### sv/rau_pkg.sv
// rau_pkg: shared types, codes and constants of the rational arithmetic unit
// no dependencies
`default_nettype none
package rau_pkg;
  localparam int unsigned WordBitsDefault = 32;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0, OP_ADD = 3'd1, OP_SUB = 3'd2, OP_MUL = 3'd3,
    OP_DIV = 3'd4, OP_LT = 3'd5, OP_EQ = 3'd6, OP_NONE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ZERO_DEN = 2'd1, ST_DIV_ZERO = 2'd2, ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_COMB, S_GCD, S_DIV, S_FIN, S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic comb;
    logic gcd_start;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic fin;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early;
    logic gcd_done;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

### sv/rational_arithmetic_unit_core.sv
// rational_arithmetic_unit_core: top level of the rational arithmetic unit
// depends on rau_pkg, rau_ctrl, rau_datapath
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_axis  | in  | a_num, a_den, b_num, b_den (128 bits)           | opcode
//  m_axis  | out | res_num, res_den, cmp_true, status (66 -> 72)   | none
//
// one request at a time: load, product, combine, binary gcd, then two
// restoring divisions, numerator then denominator; errors and the unused
// opcode go from the product step straight to the result, comparisons
// from the combine step
// reset is asynchronous, active low, and returns the sequencer to idle
// a result waits in its register until taken; input is held off meanwhile
`default_nettype none
module rational_arithmetic_unit_core import rau_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
  input  wire logic [2:0]   s_axis_tuser,  // opcode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata   // res_num, res_den, cmp_true, status
);
  cmd_t cmd;
  stat_t stat;
  logic [31:0] rnum;
  logic [30:0] rden;
  logic rcmp;
  logic [1:0] rstat;

  // sequencer
  rau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .op_i(s_axis_tuser), .stat_i(stat), .cmd_o(cmd)
  );

  // arithmetic
  rau_datapath #(.WordBits(WordBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .op_i(s_axis_tuser),
    .a_num_i(s_axis_tdata[31:0]), .a_den_i(s_axis_tdata[63:32]),
    .b_num_i(s_axis_tdata[95:64]), .b_den_i(s_axis_tdata[127:96]),
    .res_num_o(rnum), .res_den_o(rden), .res_cmp_o(rcmp), .res_status_o(rstat)
  );

  assign m_axis_tdata = {6'd0, rstat, rcmp, rden, rnum};
endmodule
`default_nettype wire

### sv/rau_datapath.sv
// rau_datapath: operand decode, cross products, binary gcd and exact division
// depends on rau_pkg
`default_nettype none
module rau_datapath import rau_pkg::*; #(
  parameter int unsigned WordBits = WordBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  output logic [31:0]      res_num_o,
  output logic [30:0]      res_den_o,
  output logic             res_cmp_o,
  output logic [1:0]       res_status_o
);
  localparam int unsigned MW = WordBits;
  localparam int unsigned PW = 2 * WordBits;
  localparam int unsigned CW = $clog2(PW + 1);

  logic [MW-1:0] an_q, ad_q, bn_q, bd_q;
  logic an_s_q, bn_s_q;
  logic [2:0] op_q;
  logic [PW-1:0] p1_q, p2_q, p3_q;
  logic [PW:0] nm_q, dm_q;
  logic ns_q;
  logic [PW:0] gx_q, gy_q;
  logic [CW-1:0] gk_q;
  logic [PW:0] rem_q, quo_q, dvs_q, dn_q;
  logic [CW:0] dc_q;
  logic div_den_q;
  logic [31:0] rnum_q;
  logic [30:0] rden_q;
  logic rcmp_q;
  logic [1:0] rst_q;
  logic early_q;

  function automatic logic [MW:0] mag(input logic [31:0] v);
    logic [MW-1:0] w;
    w = v[MW-1:0];
    mag = w[MW-1] ? {1'b0, (~w) + 1'b1} : {1'b0, w};
  endfunction

  logic [MW:0] man, mad, mbn, mbd;
  assign man = mag(a_num_i);
  assign mad = mag(a_den_i);
  assign mbn = mag(b_num_i);
  assign mbd = mag(b_den_i);

  // magnitudes are at most 2^(MW-1), which fits MW unsigned bits; keep MW+1 via products
  logic [MW:0] an_w, ad_w, bn_w, bd_w;
  logic [MW:0] anx_q, adx_q, bnx_q, bdx_q;
  assign an_w = anx_q; assign ad_w = adx_q; assign bn_w = bnx_q; assign bd_w = bdx_q;

  logic [PW+1:0] m1, m2, m3;
  always_comb begin
    m1 = '0; m2 = '0; m3 = '0;
    case (op_e'(op_q))
      OP_MUL: begin
        m1 = an_w * bn_w; m3 = ad_w * bd_w;
      end
      OP_DIV: begin
        m1 = an_w * bd_w; m3 = ad_w * bn_w;
      end
      default: begin
        m1 = an_w * bd_w; m2 = bn_w * ad_w; m3 = ad_w * bd_w;
      end
    endcase
  end

  logic [PW:0] big, small_v, diff;
  logic s1, s2, sgn;
  always_comb begin
    s1 = an_s_q;
    s2 = bn_s_q;
    if (op_q == OP_SUB || op_q == OP_LT || op_q == OP_EQ) s2 = ~bn_s_q;
    big = {1'b0, p1_q}; small_v = {1'b0, p2_q}; sgn = s1;
    if (s1 == s2) diff = big + small_v;
    else if (p1_q >= p2_q) diff = big - small_v;
    else begin diff = small_v - big; sgn = s2; end
    if (diff == '0) sgn = 1'b0;
  end

  // unreduced fraction, also seeds the gcd in the same cycle
  logic [PW:0] nm_d, dm_d;
  logic ns_d;
  always_comb begin
    nm_d = nm_q; dm_d = dm_q; ns_d = ns_q;
    case (op_e'(op_q))
      OP_NORM: begin
        nm_d = (PW+1)'(anx_q); dm_d = (PW+1)'(adx_q); ns_d = an_s_q;
      end
      OP_ADD, OP_SUB: begin
        nm_d = diff; dm_d = {1'b0, p3_q}; ns_d = sgn;
      end
      OP_MUL, OP_DIV: begin
        nm_d = {1'b0, p1_q}; dm_d = {1'b0, p3_q};
        ns_d = (p1_q != '0) && (an_s_q != bn_s_q);
      end
      default: ;
    endcase
  end

  logic [PW:0] lim;
  assign lim = (PW+1)'(1) << (WordBits - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_q <= 1'b0;
    end else if (cmd_i.load) begin
      early_q <= 1'b0;
      if (op_i == OP_NONE) early_q <= 1'b1;
      else if (mad == '0 || (op_i != OP_NORM && mbd == '0)) early_q <= 1'b1;
      else if (op_i == OP_DIV && mbn == '0) early_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      anx_q <= man; adx_q <= mad; bnx_q <= mbn; bdx_q <= mbd;
      an_s_q <= (man != '0) && (a_num_i[MW-1] != a_den_i[MW-1]);
      bn_s_q <= (mbn != '0) && (b_num_i[MW-1] != b_den_i[MW-1]);
      rnum_q <= '0; rden_q <= '0; rcmp_q <= 1'b0; rst_q <= ST_OK;
      if (op_i == OP_NONE) rst_q <= ST_OK;
      else if (mad == '0 || (op_i != OP_NORM && mbd == '0)) rst_q <= ST_ZERO_DEN;
      else if (op_i == OP_DIV && mbn == '0) rst_q <= ST_DIV_ZERO;
    end
    if (cmd_i.mul) begin
      p1_q <= m1[PW-1:0]; p2_q <= m2[PW-1:0]; p3_q <= m3[PW-1:0];
    end
    if (cmd_i.comb) begin
      nm_q <= nm_d; dm_q <= dm_d; ns_q <= ns_d;
      case (op_e'(op_q))
        OP_LT: rcmp_q <= sgn && (diff != '0);
        OP_EQ: rcmp_q <= (diff == '0);
        default: ;
      endcase
    end
    // binary gcd: strip common twos, then subtract
    if (cmd_i.gcd_start) begin
      gx_q <= nm_d; gy_q <= dm_d; gk_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (gx_q == '0) begin
        // gcd ready in gy << gk
      end else if (!gx_q[0] && !gy_q[0]) begin
        gx_q <= gx_q >> 1; gy_q <= gy_q >> 1; gk_q <= gk_q + 1'b1;
      end else if (!gx_q[0]) gx_q <= gx_q >> 1;
      else if (!gy_q[0]) gy_q <= gy_q >> 1;
      else if (gx_q >= gy_q) gx_q <= (gx_q - gy_q) >> 1;
      else gy_q <= (gy_q - gx_q) >> 1;
    end
    // restoring division: two passes, numerator then denominator
    if (cmd_i.div_start) begin
      dvs_q <= gy_q << gk_q;
      rem_q <= '0; quo_q <= nm_q; dc_q <= '0; div_den_q <= 1'b0;
    end else if (cmd_i.div_step) begin
      if (dc_q == (CW+1)'(PW + 1)) begin
        dn_q <= quo_q; rem_q <= '0; quo_q <= dm_q; dc_q <= '0; div_den_q <= 1'b1;
      end else begin
        if ({rem_q[PW-1:0], quo_q[PW]} >= dvs_q) begin
          rem_q <= {rem_q[PW-1:0], quo_q[PW]} - dvs_q;
          quo_q <= {quo_q[PW-1:0], 1'b1};
        end else begin
          rem_q <= {rem_q[PW-1:0], quo_q[PW]};
          quo_q <= {quo_q[PW-1:0], 1'b0};
        end
        dc_q <= dc_q + 1'b1;
      end
    end
    if (cmd_i.fin && op_q != OP_LT && op_q != OP_EQ) begin
      if (quo_q > lim - 1'b1 || (ns_q ? dn_q > lim : dn_q > lim - 1'b1)) begin
        rst_q <= ST_OVERFLOW;
      end else begin
        rnum_q <= ns_q ? 32'(-dn_q) : 32'(dn_q);
        rden_q <= (dn_q == '0) ? 31'd1 : 31'(quo_q);
      end
    end
  end

  assign stat_o.early    = early_q;
  assign stat_o.gcd_done = (gx_q == '0);
  assign stat_o.div_done = div_den_q && (dc_q == (CW+1)'(PW + 1));
  assign res_num_o    = rnum_q;
  assign res_den_o    = rden_q;
  assign res_cmp_o    = rcmp_q;
  assign res_status_o = rst_q;
endmodule
`default_nettype wire

### sv/rau_ctrl.sv
// rau_ctrl: sequencing state machine of the rational arithmetic unit
// depends on rau_pkg
`default_nettype none
module rau_ctrl import rau_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire logic [2:0] op_i,
  input  wire stat_t      stat_i,
  output cmd_t            cmd_o
);
  state_e state_q, state_d;
  logic cmp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) cmp_q <= (op_i == OP_LT) || (op_i == OP_EQ);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL;
      S_MUL:  state_d = stat_i.early ? S_OUT : S_COMB;
      S_COMB: state_d = cmp_q ? S_OUT : S_GCD;
      S_GCD:  if (stat_i.gcd_done) state_d = S_DIV;
      S_DIV:  if (stat_i.div_done) state_d = S_FIN;
      S_FIN:  state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == S_IDLE);
    out_valid_o = (state_q == S_OUT);
    case (state_q)
      S_IDLE: cmd_o.load = in_valid_i;
      S_MUL:  cmd_o.mul = 1'b1;
      S_COMB: begin cmd_o.comb = 1'b1; cmd_o.gcd_start = 1'b1; end
      S_GCD: begin
        cmd_o.gcd_step = ~stat_i.gcd_done;
        cmd_o.div_start = stat_i.gcd_done;
      end
      S_DIV:  cmd_o.div_step = ~stat_i.div_done;
      S_FIN:  cmd_o.fin = 1'b1;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while holding result");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == S_IDLE) else $error("load outside idle");
`endif
endmodule
`default_nettype wire

### dv/rau_checker.sv
// rau_checker: watches both stream channels of the rational arithmetic unit,
// predicts each result and compares it; depends on rau_pkg
`default_nettype none
module rau_checker import rau_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,
  input  wire logic [2:0]   s_axis_tuser,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [71:0]  m_axis_tdata,
  output int                fail_count_o,
  output int                pending_o
);
  // packed from the top bit down: status, cmp_true, res_den, res_num
  typedef struct packed {
    status_e     st;
    logic        cmp;
    logic [30:0] den;
    logic [31:0] num;
  } frac_res_t;

  frac_res_t awaited_q[$];

  assign pending_o = awaited_q.size();

  initial fail_count_o = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    fail_count_o++;
  endtask

  function automatic logic [63:0] g64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // signed values kept as sign and magnitude, like the datapath
  function automatic frac_res_t rational_result(input op_e op, input logic [127:0] d);
    frac_res_t r;
    logic signed [31:0] an, ad, bn, bd;
    logic [31:0] anm, adm, bnm, bdm;
    logic ans, bns, ns, ls, rs;
    logic [63:0] nm, dm, lm, rm, g;
    an = d[31:0]; ad = d[63:32]; bn = d[95:64]; bd = d[127:96];
    anm = an[31] ? -an : an; adm = ad[31] ? -ad : ad;
    bnm = bn[31] ? -bn : bn; bdm = bd[31] ? -bd : bd;
    r = '0;
    r.st = ST_OK;
    if (op == OP_NONE) return r;
    if (adm == 0 || (op != OP_NORM && bdm == 0)) begin
      r.st = ST_ZERO_DEN;
      return r;
    end
    ans = (anm != 0) && (an[31] != ad[31]);
    bns = (bnm != 0) && (bn[31] != bd[31]);
    lm = 64'(anm) * 64'(bdm);
    rm = 64'(bnm) * 64'(adm);
    dm = 64'(adm) * 64'(bdm);
    case (op)
      OP_NORM: begin ns = ans; nm = 64'(anm); dm = 64'(adm); end
      OP_ADD, OP_SUB, OP_LT, OP_EQ: begin
        ls = ans;
        rs = (op == OP_ADD) ? bns : !bns;
        if (ls == rs) begin ns = ls; nm = lm + rm; end
        else if (lm >= rm) begin ns = ls; nm = lm - rm; end
        else begin ns = rs; nm = rm - lm; end
        if (nm == 0) ns = 1'b0;
        if (op == OP_LT) begin r.cmp = ns; return r; end
        if (op == OP_EQ) begin r.cmp = (nm == 0); return r; end
      end
      OP_MUL: begin
        nm = 64'(anm) * 64'(bnm);
        ns = (nm != 0) && (ans != bns);
      end
      default: begin
        if (bnm == 0) begin r.st = ST_DIV_ZERO; return r; end
        nm = lm;
        ns = (nm != 0) && (ans != bns);
        dm = 64'(adm) * 64'(bnm);
      end
    endcase
    g = g64(nm, dm);
    if (g != 0) begin nm = nm / g; dm = dm / g; end
    if (nm == 0) dm = 1;
    if (dm > 64'h7fffffff || (ns ? nm > 64'h80000000 : nm > 64'h7fffffff)) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.num = ns ? -nm[31:0] : nm[31:0];
    r.den = dm[30:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    frac_res_t want, got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[65:0];
        if (awaited_q.size() == 0) report("unexpected result", 64'(m_axis_tdata), 0);
        else begin
          want = awaited_q.pop_front();
          if (got.num !== want.num) report("res_num", got.num, want.num);
          if (got.den !== want.den) report("res_den", got.den, want.den);
          if (got.cmp !== want.cmp) report("cmp_true", got.cmp, want.cmp);
          if (got.st !== want.st) report("status", got.st, want.st);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_q = {awaited_q, rational_result(op_e'(s_axis_tuser), s_axis_tdata)};
    end
  end
endmodule
`default_nettype wire

### dv/testbench.sv
// testbench: stimulus and verdict for rational_arithmetic_unit_core
// depends on rau_pkg, rau_checker and the block itself
`default_nettype none
module testbench import rau_pkg::*;;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // a_num, a_den, b_num, b_den
  logic [2:0]   s_axis_tuser = '0;  // opcode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;       // res_num, res_den, cmp_true, status
  int           fail_count, pending, cycle_count = 0;
  bit           stim_done = 1'b0;
  int           hold_off = 0;
  bit           out_taken = 1'b0;

  rational_arithmetic_unit_core dut (.*);
  rau_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial forever #6 clk_i = ~clk_i;

  // ~850 requests, each with random stalls on both sides
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result taken at the last rising edge
  always @(posedge clk_i) out_taken <= m_axis_tvalid && m_axis_tready;

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'(int'($urandom_range(0, 6)) - 3);
      3: return 32'hffffffff;
      4, 5: return 32'(int'($urandom_range(0, 200)) - 100);
      6: return 32'(int'($urandom_range(0, 200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance,
  // with tvalid still high so the next request can follow with no gap
  task automatic send(input op_e op, input logic [31:0] an, input logic [31:0] ad,
                      input logic [31:0] bn, input logic [31:0] bd);
    int gap;
    gap = $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {bd, bn, ad, an};
    // tready only follows the sequencer state, so it is settled here
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random gap after each result, plus one long hold-off
  initial begin
    int gap;
    gap = $urandom_range(0, 13);
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (out_taken) gap = $urandom_range(0, 13);
      if (hold_off > 0) begin
        m_axis_tready <= 1'b0;
        hold_off--;
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every opcode, error cases
    send(OP_NORM, 32'd6, -32'd4, 32'd0, 32'd0);
    send(OP_NORM, 32'd0, 32'd5, 32'd1, 32'd1);
    send(OP_NORM, 32'h80000000, 32'hffffffff, 32'd0, 32'd1);
    send(OP_NORM, 32'h80000000, 32'h80000000, 32'd0, 32'd1);
    send(OP_NORM, 32'd3, 32'd0, 32'd1, 32'd1);
    send(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send(OP_ADD, 32'h7fffffff, 32'd1, 32'h7fffffff, 32'd1);
    send(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send(OP_SUB, 32'h80000000, 32'd1, 32'd1, 32'd1);
    send(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send(OP_MUL, -32'd3, 32'd7, 32'd14, -32'd9);
    send(OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
    send(OP_DIV, 32'd1, 32'd2, -32'd3, 32'd4);
    send(OP_DIV, 32'd1, 32'h7fffffff, 32'h7fffffff, 32'd1);
    send(OP_LT, 32'd1, 32'd3, 32'd1, 32'd2);
    send(OP_LT, 32'd1, 32'd2, 32'd1, 32'd2);
    send(OP_LT, 32'hffffffff, 32'hffffffff, 32'h7fffffff, 32'h80000000);
    send(OP_EQ, 32'd2, 32'd4, -32'd1, -32'd2);
    send(OP_EQ, 32'd0, 32'd3, 32'd0, -32'd7);
    send(OP_ADD, 32'd1, 32'd1, 32'd1, 32'd0);
    send(OP_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send(OP_NONE, 32'hffffffff, 32'h0, 32'hffffffff, 32'h0);
    // sender pause until everything is back
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    // long receiver hold-off while requests keep coming
    @(negedge clk_i);
    hold_off = 400;
    repeat (830) begin
      logic [31:0] ad, bd;
      ad = pick_word();
      bd = pick_word();
      if (ad == 0 && $urandom_range(0, 7) != 0) ad = 32'd1;
      if (bd == 0 && $urandom_range(0, 7) != 0) bd = 32'd1;
      send(op_e'($urandom_range(0, 7)), pick_word(), ad, pick_word(), bd);
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (450) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
